// File: hdl/lcv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcv_pkg
// shared types, constants and helpers of the line clip to viewport unit
// ----------------------------------------------------------------------------
package lcv_pkg;

   localparam int COORD_BITS  = 24;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int REM_BITS    = DIFF_BITS + 1;
   localparam int CNT_BITS    = $clog2(PROD_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int IDX_BITS    = 4;
   localparam int MAX_CLIPS   = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [3:0]                   code_type;

   localparam code_type CODE_RIGHT  = 4'b1000;
   localparam code_type CODE_TOP    = 4'b0100;
   localparam code_type CODE_LEFT   = 4'b0010;
   localparam code_type CODE_BOTTOM = 4'b0001;

   localparam logic [1:0] STATUS_REJECT = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_DEGEN  = 2'd2;

   localparam logic [IDX_BITS-1:0] REG_WINDOW_LEFT   = 4'd0;
   localparam logic [IDX_BITS-1:0] REG_WINDOW_BOTTOM = 4'd1;
   localparam logic [IDX_BITS-1:0] REG_WINDOW_RIGHT  = 4'd2;
   localparam logic [IDX_BITS-1:0] REG_WINDOW_TOP    = 4'd3;
   localparam logic [IDX_BITS-1:0] REG_VIEW_LEFT     = 4'd4;
   localparam logic [IDX_BITS-1:0] REG_VIEW_BOTTOM   = 4'd5;
   localparam logic [IDX_BITS-1:0] REG_VIEW_RIGHT    = 4'd6;
   localparam logic [IDX_BITS-1:0] REG_VIEW_TOP      = 4'd7;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      coord_type  view_start_x;
      coord_type  view_start_y;
      coord_type  view_end_x;
      coord_type  view_end_y;
   } rsp_type;

   typedef struct packed {
      coord_type window_left;
      coord_type window_bottom;
      coord_type window_right;
      coord_type window_top;
      coord_type view_left;
      coord_type view_bottom;
      coord_type view_right;
      coord_type view_top;
   } cfg_type;

   typedef struct packed {
      req_type  seg;
      code_type code0;
      code_type code1;
      logic     degen;
   } item_type;

   typedef struct packed {
      logic     start;
      diff_type a;
      diff_type b;
      diff_type c;
   } md_req_type;

   typedef struct packed {
      logic     done;
      prod_type q;
   } md_rsp_type;

   function automatic code_type outcode(coord_type x, coord_type y, cfg_type cfg);
      code_type code;
      code = '0;
      if (y > cfg.window_top)
         code = code | CODE_TOP;
      else if (y < cfg.window_bottom)
         code = code | CODE_BOTTOM;
      if (x > cfg.window_right)
         code = code | CODE_RIGHT;
      else if (x < cfg.window_left)
         code = code | CODE_LEFT;
      return code;
   endfunction

   function automatic diff_type sub(coord_type a, coord_type b);
      return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
   endfunction

endpackage
`default_nettype wire

// File: hdl/lcv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcv_front
// accepts segments, computes outcodes and window check, queues them
// ----------------------------------------------------------------------------
module lcv_front import lcv_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_payload,
   output logic          q_valid,
   input  wire logic     q_pop,
   output item_type      q_item
);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   item_type               entry;
   logic                   push;
   logic                   pop;

   always_comb begin
      entry.seg   = req_payload;
      entry.code0 = outcode(req_payload.start_x, req_payload.start_y, cfg);
      entry.code1 = outcode(req_payload.end_x, req_payload.end_y, cfg);
      entry.degen = (cfg.window_right <= cfg.window_left) ||
                    (cfg.window_top <= cfg.window_bottom);
   end

   assign req_stall = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= entry;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/lcv_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcv_muldiv
// a * b / c truncated toward zero: one multiply, then one quotient bit a cycle
// ----------------------------------------------------------------------------
module lcv_muldiv import lcv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire md_req_type md_req,
   output md_rsp_type      md_rsp
);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type           state_ff;
   logic [DIFF_BITS-1:0]   ua_ff, ub_ff, uc_ff;
   logic                   neg_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [REM_BITS-1:0]    rem_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   done_ff;
   logic [REM_BITS-1:0]    rem_shift;
   logic                   ge;
   logic [DIFF_BITS-1:0]   ua_in, ub_in, uc_in;

   always_comb begin
      ua_in     = md_req.a[DIFF_BITS-1] ? DIFF_BITS'(-md_req.a) : md_req.a;
      ub_in     = md_req.b[DIFF_BITS-1] ? DIFF_BITS'(-md_req.b) : md_req.b;
      uc_in     = md_req.c[DIFF_BITS-1] ? DIFF_BITS'(-md_req.c) : md_req.c;
      rem_shift = {rem_ff[REM_BITS-2:0], prod_ff[PROD_BITS-1]};
      ge        = (rem_shift >= {1'b0, uc_ff});
   end

   always_comb begin
      md_rsp.done = done_ff;
      if (uc_ff == '0)
         md_rsp.q = '0;
      else if (neg_ff)
         md_rsp.q = -prod_type'(prod_ff);
      else
         md_rsp.q = prod_type'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            MD_IDLE: begin
               if (md_req.start) begin
                  ua_ff    <= ua_in;
                  ub_ff    <= ub_in;
                  uc_ff    <= uc_in;
                  neg_ff   <= (md_req.a[DIFF_BITS-1] ^ md_req.b[DIFF_BITS-1]) ^
                              md_req.c[DIFF_BITS-1];
                  state_ff <= MD_MUL;
               end
            end
            MD_MUL: begin
               prod_ff  <= PROD_BITS'(ua_ff * ub_ff);
               rem_ff   <= '0;
               cnt_ff   <= CNT_BITS'(PROD_BITS - 1);
               state_ff <= MD_DIV;
            end
            MD_DIV: begin
               rem_ff  <= ge ? rem_shift - {1'b0, uc_ff} : rem_shift;
               prod_ff <= {prod_ff[PROD_BITS-2:0], ge};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= MD_IDLE;
               end
            end
            default: state_ff <= MD_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hdl/lcv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcv_back
// clip sequencer and viewport mapping, owns the result register
// ----------------------------------------------------------------------------
module lcv_back import lcv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       q_valid,
   output logic            q_pop,
   input  wire item_type   q_item,
   output md_req_type      md_req,
   input  wire md_rsp_type md_rsp,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_payload
);

   typedef enum logic [2:0] {
      BK_IDLE, BK_CHECK, BK_CLIP_WAIT, BK_MAP_START, BK_MAP_WAIT, BK_EMIT
   } bk_state_type;

   bk_state_type  state_ff;
   coord_type     x0_ff, y0_ff, x1_ff, y1_ff;
   code_type      c0_ff, c1_ff;
   logic [2:0]    step_ff;
   logic [1:0]    idx_ff;
   rsp_type       res_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   code_type      cout;
   logic          trivial_accept;
   logic          trivial_reject;
   coord_type     base;
   coord_type     edge_val;
   logic          edge_is_y;
   coord_type     new_coord;
   coord_type     new_x, new_y;
   logic          load_rsp;
   rsp_type       res_init;

   assign q_pop          = (state_ff == BK_IDLE) && q_valid;
   assign trivial_accept = ((c0_ff | c1_ff) == '0);
   assign trivial_reject = ((c0_ff & c1_ff) != '0);
   assign cout           = (c0_ff != '0) ? c0_ff : c1_ff;
   assign load_rsp       = (state_ff == BK_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_payload    = rsp_ff;

   always_comb begin
      res_init        = '0;
      res_init.status = q_item.degen ? STATUS_DEGEN : STATUS_REJECT;
   end

   always_comb begin
      md_req.start = 1'b0;
      md_req.a     = '0;
      md_req.b     = '0;
      md_req.c     = '0;
      base         = '0;
      edge_val     = '0;
      edge_is_y    = 1'b0;
      if (state_ff == BK_CHECK || state_ff == BK_CLIP_WAIT) begin
         if ((cout & CODE_TOP) != '0) begin
            md_req.a = sub(x1_ff, x0_ff);
            md_req.b = sub(cfg.window_top, y0_ff);
            md_req.c = sub(y1_ff, y0_ff);
            base = x0_ff;  edge_val = cfg.window_top;  edge_is_y = 1'b1;
         end else if ((cout & CODE_BOTTOM) != '0) begin
            md_req.a = sub(x1_ff, x0_ff);
            md_req.b = sub(cfg.window_bottom, y0_ff);
            md_req.c = sub(y1_ff, y0_ff);
            base = x0_ff;  edge_val = cfg.window_bottom;  edge_is_y = 1'b1;
         end else if ((cout & CODE_RIGHT) != '0) begin
            md_req.a = sub(y1_ff, y0_ff);
            md_req.b = sub(cfg.window_right, x0_ff);
            md_req.c = sub(x1_ff, x0_ff);
            base = y0_ff;  edge_val = cfg.window_right;
         end else begin
            md_req.a = sub(y1_ff, y0_ff);
            md_req.b = sub(cfg.window_left, x0_ff);
            md_req.c = sub(x1_ff, x0_ff);
            base = y0_ff;  edge_val = cfg.window_left;
         end
         md_req.start = (state_ff == BK_CHECK) && !trivial_accept && !trivial_reject &&
                        (step_ff != 3'(MAX_CLIPS));
      end else if (state_ff == BK_MAP_START || state_ff == BK_MAP_WAIT) begin
         case (idx_ff)
            2'd0: begin
               md_req.a = sub(x0_ff, cfg.window_left);
               base = cfg.view_left;
            end
            2'd1: begin
               md_req.a = sub(y0_ff, cfg.window_bottom);
               base = cfg.view_bottom;
            end
            2'd2: begin
               md_req.a = sub(x1_ff, cfg.window_left);
               base = cfg.view_left;
            end
            default: begin
               md_req.a = sub(y1_ff, cfg.window_bottom);
               base = cfg.view_bottom;
            end
         endcase
         if (idx_ff[0]) begin
            md_req.b = sub(cfg.view_top, cfg.view_bottom);
            md_req.c = sub(cfg.window_top, cfg.window_bottom);
         end else begin
            md_req.b = sub(cfg.view_right, cfg.view_left);
            md_req.c = sub(cfg.window_right, cfg.window_left);
         end
         md_req.start = (state_ff == BK_MAP_START);
      end
      new_coord = base + md_rsp.q[COORD_BITS-1:0];
      new_x     = edge_is_y ? new_coord : edge_val;
      new_y     = edge_is_y ? edge_val : new_coord;
   end

   always_ff @(posedge clock) begin
      if (load_rsp)
         rsp_ff <= res_ff;
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            BK_IDLE: begin
               if (q_valid) begin
                  x0_ff   <= q_item.seg.start_x;
                  y0_ff   <= q_item.seg.start_y;
                  x1_ff   <= q_item.seg.end_x;
                  y1_ff   <= q_item.seg.end_y;
                  c0_ff   <= q_item.code0;
                  c1_ff   <= q_item.code1;
                  step_ff <= '0;
                  res_ff  <= res_init;
                  if (q_item.degen) begin
                     state_ff <= BK_EMIT;
                  end else begin
                     state_ff <= BK_CHECK;
                  end
               end
            end
            BK_CHECK: begin
               if (trivial_accept) begin
                  idx_ff        <= '0;
                  res_ff.status <= STATUS_ACCEPT;
                  state_ff      <= BK_MAP_START;
               end else if (trivial_reject || step_ff == 3'(MAX_CLIPS)) begin
                  res_ff.status <= STATUS_REJECT;
                  state_ff      <= BK_EMIT;
               end else begin
                  state_ff <= BK_CLIP_WAIT;
               end
            end
            BK_CLIP_WAIT: begin
               if (md_rsp.done) begin
                  if (c0_ff != '0) begin
                     x0_ff <= new_x;
                     y0_ff <= new_y;
                     c0_ff <= outcode(new_x, new_y, cfg);
                  end else begin
                     x1_ff <= new_x;
                     y1_ff <= new_y;
                     c1_ff <= outcode(new_x, new_y, cfg);
                  end
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= BK_CHECK;
               end
            end
            BK_MAP_START: state_ff <= BK_MAP_WAIT;
            BK_MAP_WAIT: begin
               if (md_rsp.done) begin
                  case (idx_ff)
                     2'd0:    res_ff.view_start_x <= new_coord;
                     2'd1:    res_ff.view_start_y <= new_coord;
                     2'd2:    res_ff.view_end_x   <= new_coord;
                     default: res_ff.view_end_y   <= new_coord;
                  endcase
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == 2'd3) begin
                     state_ff <= BK_EMIT;
                  end else begin
                     state_ff <= BK_MAP_START;
                  end
               end
            end
            BK_EMIT: begin
               if (load_rsp)
                  state_ff <= BK_IDLE;
            end
            default: state_ff <= BK_IDLE;
         endcase
      end
   end

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_IDLE && state_ff != BK_EMIT) |-> step_ff <= 3'(MAX_CLIPS))
      else $error("clip step count past limit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status != 2'd3)
      else $error("bad status on result");

   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_ACCEPT) |->
      (rsp_ff.view_start_x == '0 && rsp_ff.view_start_y == '0 &&
       rsp_ff.view_end_x == '0 && rsp_ff.view_end_y == '0))
      else $error("nonzero coordinates on non-accepted result");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != BK_IDLE)
      else $error("queue popped but sequencer stayed idle");

endmodule
`default_nettype wire

// File: hdl/line_clip_to_viewport_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_clip_to_viewport_unit
// cohen-sutherland segment clipping against a window, mapped to a viewport
// ----------------------------------------------------------------------------
//  port group  direction  payload
//  req_*       in         req_type: start_x start_y end_x end_y
//  rsp_*       out        rsp_type: status view_start/end x,y
//  csr_*       in         index 0..7 window/view registers, data 24 bits
//
//  one segment takes up to four clip steps, then four mapping divides if
//  accepted, all on the bit-serial divider in lcv_muldiv
//  a degenerate window needs no divide, and a trivial reject ends clipping at once
//  a two-beat queue lets new segments in while the sequencer works
//  reset restores the register defaults and empties queue and result slot
// ----------------------------------------------------------------------------
module line_clip_to_viewport_unit import lcv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_write,
   input  wire logic [IDX_BITS-1:0] csr_index,
   input  wire coord_type           csr_data
);

   cfg_type     cfg_ff;
   logic        q_valid;
   logic        q_pop;
   item_type    q_item;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left   <= coord_type'(12800);
         cfg_ff.window_bottom <= coord_type'(12800);
         cfg_ff.window_right  <= coord_type'(25600);
         cfg_ff.window_top    <= coord_type'(25600);
         cfg_ff.view_left     <= coord_type'(51200);
         cfg_ff.view_bottom   <= coord_type'(51200);
         cfg_ff.view_right    <= coord_type'(76800);
         cfg_ff.view_top      <= coord_type'(76800);
      end else if (csr_write) begin
         case (csr_index)
            REG_WINDOW_LEFT:   cfg_ff.window_left   <= csr_data;
            REG_WINDOW_BOTTOM: cfg_ff.window_bottom <= csr_data;
            REG_WINDOW_RIGHT:  cfg_ff.window_right  <= csr_data;
            REG_WINDOW_TOP:    cfg_ff.window_top    <= csr_data;
            REG_VIEW_LEFT:     cfg_ff.view_left     <= csr_data;
            REG_VIEW_BOTTOM:   cfg_ff.view_bottom   <= csr_data;
            REG_VIEW_RIGHT:    cfg_ff.view_right    <= csr_data;
            REG_VIEW_TOP:      cfg_ff.view_top      <= csr_data;
            default: ;
         endcase
      end
   end

   lcv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item)
   );

   lcv_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   lcv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .md_req      (md_req),
      .md_rsp      (md_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
